// ===== hdl/tagged_runtime_stack_core_assert.svh =====
// Assertion macros shared by the tagged runtime stack modules.
// Needs nothing else; the checks compile away when SYNTH is defined.
`ifndef TAGGED_RUNTIME_STACK_CORE_ASSERT_SVH
`define TAGGED_RUNTIME_STACK_CORE_ASSERT_SVH
`ifndef SYNTH
// check held while reset is low
`define TRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tagged stack check failed");
// check held on every edge, reset included
`define TRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tagged stack check failed");
`else
`define TRS_ASSERT(lbl, clk, rst, prop)
`define TRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/trs_pkg.sv =====
// Shared types and codes for the tagged runtime stack.
// Used by trs_ctrl, trs_dpath and tagged_runtime_stack_core; depends on nothing.
package trs_pkg;

  // stream widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;
  localparam int KIND_W     = 2;
  localparam int ENTRY_W    = 66;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_READ  = 3'd3,
    REQ_WRITE = 3'd4,
    REQ_CUT   = 3'd5,
    REQ_DEPTH = 3'd6,
    REQ_WALK  = 3'd7
  } req_e;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_UNDERFLW = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOT_INT  = 3'd4;
  localparam logic [2:0] ST_CORRUPT  = 3'd5;

  // value kinds
  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_REAL = 2'd1;
  localparam logic [1:0] KIND_BOOL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;    // latch the incoming transaction
    logic decode;  // check request, do writes, start read or finish
    logic rdata;   // finish a pop, peek or read from read data
    logic walk;    // one chain-walk level from read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result
    logic need_read;  // decoded request needs a memory read
    logic is_walk;    // latched request is a chain walk
    logic walk_more;  // current level passed and more levels remain
  } sts_t;

endpackage

// ===== hdl/trs_ctrl.sv =====
// Sequencer for the tagged runtime stack: accepts requests and steps the datapath.
// Depends on trs_pkg and tagged_runtime_stack_core_assert.svh.
`include "tagged_runtime_stack_core_assert.svh"
module trs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  trs_pkg::sts_t sts,
  output trs_pkg::cmd_t cmd
);
  import trs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DEC, S_RDATA, S_WALK} state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  // commands; finishing steps wait for a free output register
  always_comb begin
    cmd.take   = (state == S_IDLE) && s_tvalid;
    cmd.decode = (state == S_DEC) && sts.out_free;
    cmd.rdata  = (state == S_RDATA) && sts.out_free;
    cmd.walk   = (state == S_WALK) && (sts.walk_more || sts.out_free);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_DEC;
        end
        S_DEC: begin
          if (sts.out_free) begin
            if (!sts.need_read) state <= S_IDLE;
            else if (sts.is_walk) state <= S_WALK;
            else state <= S_RDATA;
          end
        end
        S_RDATA: begin
          if (sts.out_free) state <= S_IDLE;
        end
        S_WALK: begin
          if (!sts.walk_more && sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRS_ASSERT(a_cmd_onehot, clk, rst, $onehot0({cmd.take, cmd.decode, cmd.rdata, cmd.walk}))
  `TRS_ASSERT(a_take_to_dec, clk, rst, cmd.take |=> (state == S_DEC))
  `TRS_ASSERT(a_rdata_entry, clk, rst, (state == S_RDATA) |-> ($past(state) == S_DEC || $past(state) == S_RDATA))
  `TRS_ASSERT(a_idle_quiet, clk, rst, s_tready |-> !(cmd.decode || cmd.rdata || cmd.walk))

endmodule

// ===== hdl/trs_dpath.sv =====
// Datapath for the tagged runtime stack: entry memory, depth, walk registers, output.
// Depends on trs_pkg and tagged_runtime_stack_core_assert.svh.
`include "tagged_runtime_stack_core_assert.svh"
module trs_dpath #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  trs_pkg::cmd_t                     cmd,
  output trs_pkg::sts_t                     sts,
  input  logic [trs_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [trs_pkg::KIND_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [trs_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [trs_pkg::KIND_W-1:0]        m_tuser
);
  import trs_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > 11) ? DW : 11;

  // latched request
  req_e               req_q;
  logic [10:0]        index_q;
  logic [7:0]         levels_q;
  logic [ENTRY_W-1:0] wr_entry_q;
  logic [10:0]        cur_q;
  logic [DW-1:0]      depth_q;

  // entry memory: {kind, payload}
  logic [ENTRY_W-1:0] mem [STACK_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  // decode results
  logic [2:0]    dec_status;
  logic [DW-1:0] dec_depth_next;
  logic          dec_we;
  logic          dec_re;
  logic [CW-1:0] dec_waddr;
  logic [CW-1:0] dec_raddr;

  logic [CW-1:0] depth_w;
  logic [CW-1:0] idx_w;
  logic          full;
  logic          empty;
  logic          idx_oob;
  logic          cut_oob;

  // walk step
  logic [1:0]  rd_kind;
  logic [31:0] raw;
  logic        not_int;
  logic        corrupt;
  logic        walk_more;

  // result
  logic          emit;
  logic [2:0]    res_status;
  logic [1:0]    res_kind;
  logic [63:0]   res_payload;
  logic [DW-1:0] res_depth;
  logic [CW-1:0] res_depth_w;
  logic [9:0]    res_frame;
  logic          out_free;

  // entry made from the incoming value
  logic [ENTRY_W-1:0] new_entry;
  logic [63:0]        in_payload;

  assign in_payload = s_tdata[85:22];

  always_comb begin
    case (s_tuser)
      KIND_REAL: new_entry = {KIND_REAL, in_payload};
      KIND_BOOL: new_entry = {KIND_BOOL, 63'd0, (in_payload != 64'd0)};
      default:   new_entry = {KIND_INT, 32'd0, in_payload[31:0]};
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q      <= req_e'(s_tdata[2:0]);
      index_q    <= s_tdata[13:3];
      cur_q      <= s_tdata[13:3];
      levels_q   <= s_tdata[21:14];
      wr_entry_q <= new_entry;
    end else if (cmd.walk && walk_more) begin
      cur_q    <= raw[10:0];
      levels_q <= levels_q - 8'd1;
    end
  end

  // bounds checks
  assign depth_w = CW'(depth_q);
  assign idx_w   = CW'(index_q);
  assign full    = (depth_q == DW'(STACK_DEPTH));
  assign empty   = (depth_q == '0);
  assign idx_oob = (idx_w >= depth_w);
  assign cut_oob = (idx_w > depth_w);

  // request decode
  always_comb begin
    dec_status     = ST_OK;
    dec_depth_next = depth_q;
    dec_we         = 1'b0;
    dec_re         = 1'b0;
    dec_waddr      = depth_w;
    dec_raddr      = idx_w;
    case (req_q)
      REQ_PUSH: begin
        if (full) begin
          dec_status = ST_OVERFLOW;
        end else begin
          dec_we         = 1'b1;
          dec_depth_next = depth_q + DW'(1);
        end
      end
      REQ_POP, REQ_PEEK: begin
        dec_raddr = CW'(depth_q - DW'(1));
        if (empty) dec_status = ST_UNDERFLW;
        else dec_re = 1'b1;
      end
      REQ_READ: begin
        if (idx_oob) dec_status = ST_RANGE;
        else dec_re = 1'b1;
      end
      REQ_WRITE: begin
        dec_waddr = idx_w;
        if (idx_oob) dec_status = ST_RANGE;
        else dec_we = 1'b1;
      end
      REQ_CUT: begin
        if (cut_oob) dec_status = ST_RANGE;
        else dec_depth_next = DW'(index_q);
      end
      REQ_WALK: begin
        if (levels_q != 8'd0) begin
          if (idx_oob) dec_status = ST_RANGE;
          else dec_re = 1'b1;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // one chain level from the read entry
  assign rd_kind   = rd_data_q[65:64];
  assign raw       = rd_data_q[31:0];
  assign not_int   = (rd_kind != KIND_INT);
  assign corrupt   = raw[31] || (raw >= 32'(cur_q));
  assign walk_more = !not_int && !corrupt && (levels_q > 8'd1);

  // memory port
  assign mem_we  = cmd.decode && dec_we;
  assign mem_re  = (cmd.decode && dec_re) || (cmd.walk && walk_more);
  assign wr_addr = AW'(dec_waddr);
  assign rd_addr = cmd.walk ? AW'(raw[10:0]) : AW'(dec_raddr);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_entry_q;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_q <= mem[rd_addr];
  end

  // depth register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_q <= '0;
    end else if (cmd.decode) begin
      depth_q <= dec_depth_next;
    end else if (cmd.rdata && req_q == REQ_POP) begin
      depth_q <= depth_q - DW'(1);
    end
  end

  // result selection
  always_comb begin
    res_status  = ST_OK;
    res_kind    = KIND_INT;
    res_payload = 64'd0;
    res_depth   = depth_q;
    res_frame   = 10'd0;
    if (cmd.decode) begin
      res_status = dec_status;
      res_depth  = dec_depth_next;
      if (req_q == REQ_WALK) res_frame = index_q[9:0];
    end else if (cmd.rdata) begin
      res_kind    = rd_kind;
      res_payload = rd_data_q[63:0];
      if (req_q == REQ_POP) res_depth = depth_q - DW'(1);
    end else if (cmd.walk) begin
      if (not_int) begin
        res_status = ST_NOT_INT;
        res_frame  = cur_q[9:0];
      end else if (corrupt) begin
        res_status = ST_CORRUPT;
        res_frame  = cur_q[9:0];
      end else begin
        res_frame = raw[9:0];
      end
    end
  end

  assign res_depth_w = CW'(res_depth);
  assign emit = (cmd.decode && !dec_re) || cmd.rdata || (cmd.walk && !walk_more);
  assign out_free = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {res_frame, res_depth_w[10:0], res_payload, res_status};
      m_tuser <= res_kind;
    end
  end

  always_comb begin
    sts.out_free  = out_free;
    sts.need_read = dec_re;
    sts.is_walk   = (req_q == REQ_WALK);
    sts.walk_more = walk_more;
  end

  `TRS_ASSERT(a_depth_bound, clk, rst, depth_q <= DW'(STACK_DEPTH))
  `TRS_ASSERT(a_no_overwrite, clk, rst, emit |-> out_free)
  `TRS_ASSERT(a_walk_descends, clk, rst, (cmd.walk && walk_more) |=> (cur_q < $past(cur_q)))
  `TRS_ASSERT(a_port_exclusive, clk, rst, !(mem_we && mem_re))

endmodule

// ===== hdl/tagged_runtime_stack_core.sv =====
// Tagged runtime stack: one result transaction per request transaction.
// Push, write, cut and depth finish in the decode step; pop, peek and read finish in a
// later step from the registered read of the entry memory. A chain walk makes one
// memory read per level followed; a bad link or base ends it early.
// The next request is taken once the result is queued; requests do not overlap.
// Synchronous active-high reset empties the stack; entry contents are not cleared.
module tagged_runtime_stack_core #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // tdata: req_type[2:0], index[13:3], walk_levels[21:14], value_payload[85:22]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [trs_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: value_kind[1:0]
  input  logic [trs_pkg::KIND_W-1:0]     s_tuser,
  // tdata: status[2:0], read_payload[66:3], depth[77:67], frame_index[87:78]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [trs_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: read_kind[1:0]
  output logic [trs_pkg::KIND_W-1:0]     m_tuser
);
  import trs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trs_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for tagged_runtime_stack_core: stack, indexed and chain-walk requests.
// Needs trs_pkg and the core RTL; keeps its own shadow stack and predicts every response.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  localparam int STACK_ENTRIES = 1024;
  // a kind code outside the defined set, stored as an integer
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [63:0] payload;
    logic [10:0] depth;
    logic [9:0]  frame;
  } stack_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;

  // shadow of the stack contents: {kind, payload}
  logic [65:0] shadow_entry [STACK_ENTRIES];
  logic [10:0] shadow_depth = '0;
  stack_rsp_t owed_responses [$];

  int  fail_count = 0;
  int  hold_request = 0;
  bit  quiet = 1'b0;
  int  requests_sent = 0;
  int  responses_seen = 0;
  int  status_seen [8];
  int  deepest_walk = 0;

  tagged_runtime_stack_core #(.STACK_DEPTH(STACK_ENTRIES)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // normalize a value as the stack stores it
  function automatic logic [65:0] tag_entry(logic [1:0] kind, logic [63:0] pay);
    case (kind)
      KIND_REAL: return {KIND_REAL, pay};
      KIND_BOOL: return {KIND_BOOL, 63'd0, |pay};
      default:   return {KIND_INT, 32'd0, pay[31:0]};
    endcase
  endfunction

  // apply one request to the shadow stack and work out its response
  function automatic stack_rsp_t apply_stack_request(req_e op, logic [10:0] idx,
                                                     logic [7:0] lvl, logic [1:0] kind,
                                                     logic [63:0] pay);
    stack_rsp_t rsp;
    logic [31:0] cur;
    logic [31:0] link;
    rsp.status = ST_OK;
    rsp.kind = KIND_INT;
    rsp.payload = '0;
    rsp.frame = '0;
    case (op)
      REQ_PUSH: begin
        if (shadow_depth >= STACK_ENTRIES) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          shadow_entry[shadow_depth] = tag_entry(kind, pay);
          shadow_depth++;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (shadow_depth == 0) begin
          rsp.status = ST_UNDERFLW;
        end else begin
          {rsp.kind, rsp.payload} = shadow_entry[shadow_depth - 1];
          if (op == REQ_POP) shadow_depth--;
        end
      end
      REQ_READ: begin
        if (idx >= shadow_depth) rsp.status = ST_RANGE;
        else {rsp.kind, rsp.payload} = shadow_entry[idx];
      end
      REQ_WRITE: begin
        if (idx >= shadow_depth) rsp.status = ST_RANGE;
        else shadow_entry[idx] = tag_entry(kind, pay);
      end
      REQ_CUT: begin
        if (idx > shadow_depth) rsp.status = ST_RANGE;
        else shadow_depth = idx;
      end
      REQ_DEPTH: ;
      default: begin
        // follow static links, stopping at the first bad level
        cur = {21'd0, idx};
        for (int i = 0; i < lvl; i++) begin
          if (cur >= shadow_depth) begin
            rsp.status = ST_RANGE;
            break;
          end
          if (shadow_entry[cur][65:64] != KIND_INT) begin
            rsp.status = ST_NOT_INT;
            break;
          end
          link = shadow_entry[cur][31:0];
          if (link[31] || link >= cur) begin
            rsp.status = ST_CORRUPT;
            break;
          end
          cur = link;
        end
        rsp.frame = cur[9:0];
        if (rsp.status == ST_OK && int'(lvl) > deepest_walk) deepest_walk = lvl;
      end
    endcase
    rsp.depth = shadow_depth;
    return rsp;
  endfunction

  // offer one request transaction, with an occasional gap first
  task automatic send_request(req_e op, logic [10:0] idx, logic [7:0] lvl,
                              logic [1:0] kind, logic [63:0] pay);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tdata  <= {2'b00, pay, lvl, idx, op};
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    owed_responses.insert(owed_responses.size(),
                          apply_stack_request(op, idx, lvl, kind, pay));
    requests_sent++;
  endtask

  // random value; integer links mostly point below the given position
  function automatic void pick_value(input int pos, output logic [1:0] kind,
                                     output logic [63:0] pay);
    logic [31:0] link;
    link = (pos <= 0) ? 32'd0 : 32'($urandom_range(0, pos - 1));
    pay = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      6: kind = KIND_INT;  // raw low word, usually a bad link
      7: kind = KIND_REAL;
      8: begin
        kind = KIND_BOOL;
        if ($urandom_range(0, 1) == 0) pay = '0;
      end
      9: begin
        kind = KIND_SPARE;
        pay[31:0] = link;
      end
      default: begin
        kind = KIND_INT;
        pay[31:0] = link;
      end
    endcase
  endfunction

  // mostly a live entry, sometimes the boundary or anything the field holds
  function automatic logic [10:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 11'($urandom_range(0, 2047));
      1: return shadow_depth;
      default: return (shadow_depth == 0) ? 11'd0 : 11'($urandom_range(0, shadow_depth - 1));
    endcase
  endfunction

  // empty stack: every access faults except cut to zero, a zero-level walk and depth
  task automatic test_empty_stack();
    send_request(REQ_POP,   11'd0,    8'd0, KIND_INT, 64'd0);
    send_request(REQ_PEEK,  11'd0,    8'd0, KIND_INT, 64'd0);
    send_request(REQ_READ,  11'd0,    8'd0, KIND_INT, 64'd0);
    send_request(REQ_WRITE, 11'd0,    8'd0, KIND_INT, 64'd7);
    send_request(REQ_CUT,   11'd1,    8'd0, KIND_INT, 64'd0);
    send_request(REQ_CUT,   11'd0,    8'd0, KIND_INT, 64'd0);
    send_request(REQ_WALK,  11'd0,    8'd1, KIND_INT, 64'd0);
    send_request(REQ_WALK,  11'd2047, 8'd0, KIND_INT, 64'd0);
    send_request(REQ_DEPTH, 11'd0,    8'd0, KIND_INT, 64'd0);
  endtask

  // storage rules for each kind, indexed access and cut limits
  task automatic test_tagged_values();
    send_request(REQ_PUSH,  11'd0, 8'd0, KIND_INT,   64'hFFFF_FFFF_8000_0001);
    send_request(REQ_PUSH,  11'd0, 8'd0, KIND_REAL,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_PUSH,  11'd0, 8'd0, KIND_BOOL,  64'h8000_0000_0000_0000);
    send_request(REQ_PUSH,  11'd0, 8'd0, KIND_BOOL,  64'd0);
    send_request(REQ_PUSH,  11'd0, 8'd0, KIND_SPARE, 64'h1234_5678_9ABC_DEF0);
    send_request(REQ_READ,  11'd0, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_READ,  11'd4, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_READ,  11'd5, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_WRITE, 11'd1, 8'd0, KIND_BOOL,  64'h0000_0100_0000_0000);
    send_request(REQ_READ,  11'd1, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_PEEK,  11'd0, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_POP,   11'd0, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_CUT,   11'd2, 8'd0, KIND_INT,   64'd0);
    send_request(REQ_CUT,   11'd5, 8'd0, KIND_INT,   64'd0);
  endtask

  // small frame chain with one of each link fault
  task automatic test_chain_walk();
    send_request(REQ_CUT,  11'd0, 8'd0, KIND_INT,  64'd0);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'd0);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'd0);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'd1);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_REAL, 64'h3FF0_0000_0000_0000);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'h0000_0000_8000_0000);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'd5);
    send_request(REQ_PUSH, 11'd0, 8'd0, KIND_INT,  64'd2);
    send_request(REQ_WALK, 11'd6, 8'd3,   KIND_INT, 64'd0);  // 6 -> 2 -> 1 -> 0
    send_request(REQ_WALK, 11'd6, 8'd4,   KIND_INT, 64'd0);  // bottom links to itself
    send_request(REQ_WALK, 11'd6, 8'd0,   KIND_INT, 64'd0);
    send_request(REQ_WALK, 11'd3, 8'd1,   KIND_INT, 64'd0);  // real entry
    send_request(REQ_WALK, 11'd4, 8'd1,   KIND_INT, 64'd0);  // negative link
    send_request(REQ_WALK, 11'd5, 8'd2,   KIND_INT, 64'd0);  // self link
    send_request(REQ_WALK, 11'd7, 8'd1,   KIND_INT, 64'd0);  // above the top
    send_request(REQ_WALK, 11'd6, 8'd255, KIND_INT, 64'd0);
  endtask

  // pushes behind a long output stall, then probe the top of the new frames
  task automatic test_output_backpressure();
    logic [63:0] pay;
    logic [1:0] kind;
    int pos;
    hold_request = 400;
    repeat (40) begin
      pos = shadow_depth;
      pay = {$urandom, $urandom};
      kind = KIND_INT;
      case ($urandom_range(0, 15))
        0: kind = KIND_REAL;
        1: pay[31:0] = (pos == 0) ? 32'd0 : 32'($urandom_range(0, pos - 1));
        default: pay[31:0] = (pos == 0) ? 32'd0 : 32'(pos - 1);
      endcase
      send_request(REQ_PUSH, 11'd0, 8'd0, kind, pay);
    end
    send_request(REQ_WALK,  shadow_depth - 11'd1, 8'd255, KIND_INT,  64'd0);
    send_request(REQ_READ,  shadow_depth - 11'd1, 8'd0,   KIND_INT,  64'd0);
    send_request(REQ_READ,  shadow_depth,         8'd0,   KIND_INT,  64'd0);
    send_request(REQ_WRITE, shadow_depth - 11'd1, 8'd0,   KIND_INT,  64'd3);
    send_request(REQ_CUT,   shadow_depth + 11'd1, 8'd0,   KIND_INT,  64'd0);
    send_request(REQ_CUT,   shadow_depth,         8'd0,   KIND_INT,  64'd0);
  endtask

  // random mix weighted toward well-formed frames and deep walks
  task automatic test_random_traffic(int count);
    req_e op;
    logic [10:0] idx;
    logic [7:0] lvl;
    logic [1:0] kind;
    logic [63:0] pay;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n == count - 120) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      idx = pick_index();
      lvl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 12));
      if (pick < 26) op = REQ_PUSH;
      else if (pick < 34) op = REQ_POP;
      else if (pick < 40) op = REQ_PEEK;
      else if (pick < 52) op = REQ_READ;
      else if (pick < 62) op = REQ_WRITE;
      else if (pick < 68) op = REQ_CUT;
      else if (pick < 72) op = REQ_DEPTH;
      else op = REQ_WALK;
      if (op == REQ_CUT && $urandom_range(0, 3) != 0) begin
        idx = (shadow_depth < 8) ? 11'd0 : 11'(shadow_depth - $urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) idx = shadow_depth + 11'd1;
      end
      pick_value((op == REQ_PUSH) ? int'(shadow_depth) : int'(idx), kind, pay);
      send_request(op, idx, lvl, kind, pay);
    end
  endtask

  // output side: random stalls, plus the long hold-off when a test asks
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // compare each response transaction with the oldest prediction
  always @(posedge clk) begin : check_responses
    stack_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      responses_seen++;
      status_seen[m_tdata[2:0]]++;
      if (owed_responses.size() == 0) begin
        $error("response transaction with none outstanding");
        fail_count++;
      end else begin
        want = owed_responses.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tuser !== want.kind) begin
          $error("read_kind: expected %0d, actual %0d", want.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata[66:3] !== want.payload) begin
          $error("read_payload: expected %h, actual %h", want.payload, m_tdata[66:3]);
          fail_count++;
        end
        if (m_tdata[77:67] !== want.depth) begin
          $error("depth: expected %0d, actual %0d", want.depth, m_tdata[77:67]);
          fail_count++;
        end
        if (m_tdata[87:78] !== want.frame) begin
          $error("frame_index: expected %0d, actual %0d", want.frame, m_tdata[87:78]);
          fail_count++;
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #25_000_000;
    $display("tagged_runtime_stack_core verification failed");
    $finish;
  end

  initial begin
    foreach (shadow_entry[i]) shadow_entry[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_tagged_values();
    test_chain_walk();
    test_output_backpressure();
    test_random_traffic(465);
    // let every outstanding response drain
    s_tvalid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d responses for %0d requests; deepest clean chain walk %0d levels.",
             responses_seen, requests_sent, deepest_walk);
    $display("Status mix: ok %0d, overflow %0d, underflow %0d, range %0d, not int %0d",
             status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLW],
             status_seen[ST_RANGE], status_seen[ST_NOT_INT]);
    $display("Corrupt links seen: %0d", status_seen[ST_CORRUPT]);
    if (fail_count == 0) begin
      $display("tagged_runtime_stack_core verification clean");
    end else begin
      $display("tagged_runtime_stack_core verification failed");
    end
    $finish;
  end

endmodule
